/* rtl/dpsm_pkg.sv */
package dpsm_pkg;

    // Table size and page geometry
    localparam int MAX_PAGES_DEF = 16;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = 12;
    localparam int OFF_W         = PAGE_SHIFT;
    localparam int TAG_W         = 64 - PAGE_SHIFT;
    localparam int DATA_W        = 64;
    localparam int BYTE_LANES    = 8;
    localparam int LANE_SEL_W    = 3;
    localparam int PAGE_ROWS     = PAGE_BYTES / BYTE_LANES;
    localparam int ROW_W         = OFF_W - LANE_SEL_W;
    localparam int TAG_LANES     = 16;
    localparam int TL_W          = 4;

    // Operation codes
    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;

    // Access size codes
    localparam logic [1:0] SZ_1B = 2'd0;
    localparam logic [1:0] SZ_2B = 2'd1;
    localparam logic [1:0] SZ_4B = 2'd2;
    localparam logic [1:0] SZ_8B = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_CROSS    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Classified request handed from front to back
    typedef struct packed {
        logic [1:0]        func;
        logic [TAG_W-1:0]  tag;
        logic [OFF_W-1:0]  offset;
        logic [1:0]        size_code;
        logic              crosses;
        logic [DATA_W-1:0] wdata;
    } t_cmd;

endpackage

/* rtl/dpsm_if.sv */
interface dpsm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [63:0]        byte_address;
    logic [1:0]         size_code;
    logic signed [63:0] write_data;

    modport source (output valid, func, byte_address, size_code, write_data, input ready);
    modport sink   (input valid, func, byte_address, size_code, write_data, output ready);
endinterface

interface dpsm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] read_data;
    logic [1:0]         status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

/* rtl/dpsm_ram.sv */
module dpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dpsm_front.sv */
module dpsm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dpsm_req_if.sink       i_req,
    output logic           o_cmd_vld,
    output dpsm_pkg::t_cmd o_cmd,
    input  logic           i_cmd_rdy
);
    import dpsm_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd             w_cmd;
    logic [OFF_W:0]   w_nbytes;
    logic [OFF_W:0]   w_end;
    logic             w_push;
    logic             w_pop;

    t_cmd             r_q [QDEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // Classify: page number, offset and page crossing
    always_comb begin
        w_nbytes        = (OFF_W+1)'(1) << i_req.size_code;
        w_end           = {1'b0, i_req.byte_address[OFF_W-1:0]} + w_nbytes;
        w_cmd.func      = i_req.func;
        w_cmd.tag       = i_req.byte_address[63:PAGE_SHIFT];
        w_cmd.offset    = i_req.byte_address[OFF_W-1:0];
        w_cmd.size_code = i_req.size_code;
        w_cmd.crosses   = w_end > (OFF_W+1)'(PAGE_BYTES);
        w_cmd.wdata     = i_req.write_data;
    end

    assign i_req.ready = (r_cnt != 2'(QDEPTH));
    assign w_push      = i_req.valid & i_req.ready;
    assign o_cmd_vld   = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_vld & i_cmd_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

/* rtl/dpsm_back.sv */
module dpsm_back #(
    parameter int MAX_PAGES = dpsm_pkg::MAX_PAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_vld,
    input  dpsm_pkg::t_cmd i_cmd,
    output logic           o_cmd_rdy,
    dpsm_rsp_if.source     o_rsp
);
    import dpsm_pkg::*;

    localparam int NROW   = (MAX_PAGES + TAG_LANES - 1) / TAG_LANES;
    localparam int RW     = (NROW > 1) ? $clog2(NROW) : 1;
    localparam int NSLOT  = NROW * TAG_LANES;
    localparam int PSW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SFW    = RW + TL_W;
    localparam int DDEPTH = MAX_PAGES * PAGE_ROWS;
    localparam int DAW    = $clog2(DDEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRD,
        S_TCMP,
        S_ALLOC,
        S_CLR,
        S_DWR,
        S_DRD,
        S_DGET
    } t_state;

    t_state                r_state;
    logic                  r_done;
    t_cmd                  r_cmd;
    logic [RW-1:0]         r_row;
    logic [PSW-1:0]        r_slot;
    logic                  r_ffound;
    logic [RW-1:0]         r_frow;
    logic [TL_W-1:0]       r_flane;
    logic [ROW_W-1:0]      r_crow;
    logic [MAX_PAGES-1:0]  r_valid;
    logic [DATA_W-1:0]     r_rd;
    logic [1:0]            r_st;
    logic                  r_out_vld;
    logic [DATA_W-1:0]     r_out_data;
    logic [1:0]            r_out_st;

    logic [TAG_W-1:0]      w_tag_rd [TAG_LANES];
    logic                  w_tag_we;
    logic [NSLOT-1:0]      w_vpad;
    logic [NSLOT-1:0]      w_epad;
    logic [TAG_LANES-1:0]  w_vrow;
    logic [TAG_LANES-1:0]  w_erow;
    logic [TAG_LANES-1:0]  w_hitv;
    logic [TAG_LANES-1:0]  w_freev;
    logic [TL_W-1:0]       w_hit_lane;
    logic [TL_W-1:0]       w_free_lane;
    logic [SFW-1:0]        w_hfull;
    logic [SFW-1:0]        w_ffull;
    logic [PSW-1:0]        w_hslot;
    logic [PSW-1:0]        w_fslot;
    logic                  w_last_row;
    logic                  w_out_free;

    logic [LANE_SEL_W-1:0] w_b;
    logic [ROW_W-1:0]      w_brow;
    logic [3:0]            w_nb;
    logic [LANE_SEL_W-1:0] w_k     [BYTE_LANES];
    logic [ROW_W-1:0]      w_lrow  [BYTE_LANES];
    logic [ROW_W-1:0]      w_rsel  [BYTE_LANES];
    logic [DAW-1:0]        w_daddr [BYTE_LANES];
    logic                  w_dwe   [BYTE_LANES];
    logic [7:0]            w_dwd   [BYTE_LANES];
    logic [7:0]            w_drd   [BYTE_LANES];
    logic [DATA_W-1:0]     w_raw;
    logic [DATA_W-1:0]     w_sext;

    assign o_cmd_rdy = (r_state == S_IDLE) & ~r_done;
    assign w_out_free = ~r_out_vld | o_rsp.ready;

    // Tag table: one small RAM per lane, one row of lanes compared per scan step
    assign w_tag_we = (r_state == S_ALLOC);

    for (genvar j = 0; j < TAG_LANES; j++) begin : g_tag
        if (j < MAX_PAGES) begin : g_lane
            dpsm_ram #(
                .WIDTH (TAG_W),
                .DEPTH (NROW)
            ) u_tag_ram (
                .i_clk   (i_clk),
                .i_we    (w_tag_we && (r_flane == TL_W'(j))),
                .i_waddr (r_frow),
                .i_wdata (r_cmd.tag),
                .i_raddr (r_row),
                .o_rdata (w_tag_rd[j])
            );
        end else begin : g_none
            assign w_tag_rd[j] = '0;
        end
    end

    assign w_vpad = NSLOT'(r_valid);
    assign w_epad = NSLOT'({MAX_PAGES{1'b1}});
    assign w_vrow = w_vpad[r_row*TAG_LANES +: TAG_LANES];
    assign w_erow = w_epad[r_row*TAG_LANES +: TAG_LANES];

    always_comb begin
        for (int j = 0; j < TAG_LANES; j++) begin
            w_hitv[j]  = w_vrow[j] & (w_tag_rd[j] == r_cmd.tag);
            w_freev[j] = ~w_vrow[j] & w_erow[j];
        end
    end

    // Lowest lane wins for both the hit and the free slot
    always_comb begin
        w_hit_lane  = '0;
        w_free_lane = '0;
        for (int j = TAG_LANES - 1; j >= 0; j--) begin
            if (w_hitv[j]) begin
                w_hit_lane = TL_W'(j);
            end
            if (w_freev[j]) begin
                w_free_lane = TL_W'(j);
            end
        end
    end

    assign w_hfull    = {r_row, w_hit_lane};
    assign w_ffull    = {r_frow, r_flane};
    assign w_hslot    = w_hfull[PSW-1:0];
    assign w_fslot    = w_ffull[PSW-1:0];
    assign w_last_row = (r_row == RW'(NROW - 1));

    // Data store: eight byte lanes, so an unaligned access touches each lane once
    assign w_b    = r_cmd.offset[LANE_SEL_W-1:0];
    assign w_brow = r_cmd.offset[OFF_W-1:LANE_SEL_W];
    assign w_nb   = 4'd1 << r_cmd.size_code;

    for (genvar l = 0; l < BYTE_LANES; l++) begin : g_data
        assign w_k[l]     = LANE_SEL_W'(l) - w_b;
        assign w_lrow[l]  = w_brow + ROW_W'(LANE_SEL_W'(l) < w_b);
        assign w_rsel[l]  = (r_state == S_CLR) ? r_crow : w_lrow[l];
        assign w_daddr[l] = DAW'({r_slot, w_rsel[l]});
        assign w_dwe[l]   = (r_state == S_CLR) |
                            ((r_state == S_DWR) & ({1'b0, w_k[l]} < w_nb));
        assign w_dwd[l]   = (r_state == S_CLR) ? 8'd0 : r_cmd.wdata[{w_k[l], 3'b000} +: 8];

        dpsm_ram #(
            .WIDTH (8),
            .DEPTH (DDEPTH)
        ) u_data_ram (
            .i_clk   (i_clk),
            .i_we    (w_dwe[l]),
            .i_waddr (w_daddr[l]),
            .i_wdata (w_dwd[l]),
            .i_raddr (w_daddr[l]),
            .o_rdata (w_drd[l])
        );
    end

    always_comb begin
        logic [LANE_SEL_W-1:0] idx;
        idx   = '0;
        w_raw = '0;
        for (int k = 0; k < BYTE_LANES; k++) begin
            idx = w_b + LANE_SEL_W'(k);
            w_raw[8*k +: 8] = w_drd[idx];
        end
    end

    always_comb begin
        case (r_cmd.size_code)
            SZ_1B:   w_sext = {{56{w_raw[7]}}, w_raw[7:0]};
            SZ_2B:   w_sext = {{48{w_raw[15]}}, w_raw[15:0]};
            SZ_4B:   w_sext = {{32{w_raw[31]}}, w_raw[31:0]};
            SZ_8B:   w_sext = w_raw;
            default: w_sext = w_raw;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
            r_ffound  <= 1'b0;
        end else begin
            // Move a finished result into the output register
            if (r_done && w_out_free) begin
                r_done     <= 1'b0;
                r_out_vld  <= 1'b1;
                r_out_data <= r_rd;
                r_out_st   <= r_st;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld && !r_done) begin
                        r_cmd    <= i_cmd;
                        r_row    <= '0;
                        r_ffound <= 1'b0;
                        r_rd     <= '0;
                        if (i_cmd.func == FN_WRITE && i_cmd.crosses) begin
                            r_st   <= ST_CROSS;
                            r_done <= 1'b1;
                        end else if (i_cmd.func == FN_READ || i_cmd.func == FN_WRITE ||
                                     i_cmd.func == FN_FREE) begin
                            r_st    <= ST_OK;
                            r_state <= S_TRD;
                        end else begin
                            r_st   <= ST_OK;
                            r_done <= 1'b1;
                        end
                    end
                end
                S_TRD: begin
                    r_state <= S_TCMP;
                end
                S_TCMP: begin
                    if (|w_hitv) begin
                        r_slot <= w_hslot;
                        case (r_cmd.func)
                            FN_READ: begin
                                if (r_cmd.crosses) begin
                                    r_st    <= ST_CROSS;
                                    r_done  <= 1'b1;
                                    r_state <= S_IDLE;
                                end else begin
                                    r_state <= S_DRD;
                                end
                            end
                            FN_WRITE: begin
                                r_state <= S_DWR;
                            end
                            default: begin
                                r_valid[w_hslot] <= 1'b0;
                                r_done           <= 1'b1;
                                r_state          <= S_IDLE;
                            end
                        endcase
                    end else begin
                        if (!r_ffound && (|w_freev)) begin
                            r_ffound <= 1'b1;
                            r_frow   <= r_row;
                            r_flane  <= w_free_lane;
                        end
                        if (w_last_row) begin
                            if (r_cmd.func != FN_WRITE) begin
                                r_st    <= ST_UNMAPPED;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else if (r_ffound || (|w_freev)) begin
                                r_state <= S_ALLOC;
                            end else begin
                                r_st    <= ST_FULL;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_state <= S_TRD;
                        end
                    end
                end
                S_ALLOC: begin
                    // Tag goes in this cycle; the page is zeroed next
                    r_valid[w_fslot] <= 1'b1;
                    r_slot           <= w_fslot;
                    r_crow           <= '0;
                    r_state          <= S_CLR;
                end
                S_CLR: begin
                    r_crow <= r_crow + ROW_W'(1);
                    if (r_crow == ROW_W'(PAGE_ROWS - 1)) begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DRD: begin
                    r_state <= S_DGET;
                end
                S_DGET: begin
                    r_rd    <= w_sext;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.read_data = r_out_data;
    assign o_rsp.status    = r_out_st;

endmodule

/* rtl/demand_paged_sparse_memory_top.sv */
// The back takes one item at a time; it takes the next once the last result has moved on
// to the output register. The tag scan reads one row of 16 slots from the tag RAMs, then
// compares it, row after row, until a hit or the last row.
// A write that allocates a page adds a tag write plus a 512-row zeroing sweep.
// Reset (synchronous, active low) empties the queue, the sequencer and the slot valid bits.
module demand_paged_sparse_memory_top #(
    parameter int MAX_PAGES = dpsm_pkg::MAX_PAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpsm_req_if.sink   i_req,
    dpsm_rsp_if.source o_rsp
);
    import dpsm_pkg::*;

    // Front to back: classified items wait in a two-entry queue, so the front
    // keeps taking items while the back scans tags, sweeps a new page or
    // holds a result for a stalled consumer.
    t_cmd w_cmd;
    logic w_cmd_vld;
    logic w_cmd_rdy;

    // Front: split the address into page number and offset, flag page crossings,
    // and queue the item.
    dpsm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_rdy (w_cmd_rdy)
    );

    // Back: fully associative page lookup, allocation with zeroing, byte-lane
    // data access, and the output register. Page storage is never cleared at
    // reset: every page is zeroed when it is allocated, before its first access.
    dpsm_back #(
        .MAX_PAGES (MAX_PAGES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_rdy (w_cmd_rdy),
        .o_rsp     (o_rsp)
    );

endmodule

/* sim/tb_demand_paged_sparse_memory_top.sv */
module tb_demand_paged_sparse_memory_top;
    import dpsm_pkg::*;

    // Table size of the instance below (its default)
    localparam int TB_PAGES   = MAX_PAGES_DEF;
    // Operation code with no function; answers ok and changes nothing
    localparam logic [1:0] FN_UNUSED = 2'd3;
    // Percent of cycles in which each side idles
    localparam int IDLE_PCT   = 34;
    localparam int RAND_ITEMS = 1900;
    // Random items [CALM_LO, CALM_HI) run with no idling on either side
    localparam int CALM_LO    = 1200;
    localparam int CALM_HI    = 1500;
    // Candidate pages for random traffic; more than the table holds so it fills
    localparam int POOL       = 24;
    // Cycles with no accept on either side before the run is abandoned
    localparam int STALL_LIMIT = 6000;
    // Quiet cycles after the last result
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        logic [1:0]  func;
        logic [63:0] addr;
        logic [1:0]  size_code;
        logic [63:0] wdata;
        bit          drain;  // hold until every outstanding result is back
        bit          calm;   // no idling while this item is in flight
    } t_mem_req;

    typedef struct {
        logic [63:0] rdata;
        logic [1:0]  status;
    } t_mem_rsp;

    logic i_clk;
    logic i_rst_n;

    dpsm_req_if req_if ();
    dpsm_rsp_if rsp_if ();

    demand_paged_sparse_memory_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // ------------------------------------------------------------------
    // Shadow of the page table and page contents
    // ------------------------------------------------------------------
    logic [TAG_W-1:0] shadow_tag   [TB_PAGES];
    bit               shadow_valid [TB_PAGES];
    logic [7:0]       shadow_bytes [TB_PAGES][PAGE_BYTES];

    t_mem_req req_backlog[$];      // items not yet driven
    t_mem_rsp predicted_rsp_q[$];  // results owed by the block, oldest first
    t_mem_req cur_req;             // item currently on the request bus
    int       reqs_taken;
    int       rsps_taken;
    int       n_errors;
    int       stall_cycles;
    bit       calm_mode;

    // Apply one item to the shadow memory and return the answer it earns.
    // Order of checks: mapping first for reads, crossing first for writes.
    function automatic t_mem_rsp mem_model_access(input t_mem_req rq);
        t_mem_rsp         rs;
        logic [TAG_W-1:0] tag;
        int               off;
        int               nbytes;
        bit               crosses;
        int               slot;
        logic [63:0]      raw;
        rs.rdata  = '0;
        rs.status = ST_OK;
        tag       = rq.addr[63:PAGE_SHIFT];
        off       = int'(rq.addr[OFF_W-1:0]);
        nbytes    = 1 << rq.size_code;
        crosses   = (off + nbytes) > PAGE_BYTES;
        slot      = -1;
        for (int i = 0; i < TB_PAGES; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_tag[i] == tag)
                slot = i;
        end
        case (rq.func)
            FN_READ: begin
                if (slot < 0) begin
                    rs.status = ST_UNMAPPED;
                end else if (crosses) begin
                    rs.status = ST_CROSS;
                end else begin
                    raw = '0;
                    for (int k = 0; k < nbytes; k++)
                        raw[8*k +: 8] = shadow_bytes[slot][off + k];
                    case (rq.size_code)
                        SZ_1B:   rs.rdata = {{56{raw[7]}}, raw[7:0]};
                        SZ_2B:   rs.rdata = {{48{raw[15]}}, raw[15:0]};
                        SZ_4B:   rs.rdata = {{32{raw[31]}}, raw[31:0]};
                        default: rs.rdata = raw;
                    endcase
                end
            end
            FN_WRITE: begin
                if (crosses) begin
                    rs.status = ST_CROSS;
                end else begin
                    // Claim the lowest free slot and zero it
                    if (slot < 0) begin
                        for (int i = TB_PAGES - 1; i >= 0; i--) begin
                            if (!shadow_valid[i])
                                slot = i;
                        end
                        if (slot >= 0) begin
                            shadow_valid[slot] = 1'b1;
                            shadow_tag[slot]   = tag;
                            for (int b = 0; b < PAGE_BYTES; b++)
                                shadow_bytes[slot][b] = 8'h00;
                        end
                    end
                    if (slot < 0) begin
                        rs.status = ST_FULL;
                    end else begin
                        for (int k = 0; k < nbytes; k++)
                            shadow_bytes[slot][off + k] = rq.wdata[8*k +: 8];
                    end
                end
            end
            FN_FREE: begin
                if (slot < 0)
                    rs.status = ST_UNMAPPED;
                else
                    shadow_valid[slot] = 1'b0;
            end
            default: ;
        endcase
        return rs;
    endfunction

    task automatic queue_req(input logic [1:0] fn, input logic [63:0] ad,
                             input logic [1:0] sz, input logic [63:0] wd,
                             input bit drain, input bit calm);
        t_mem_req rq;
        rq.func      = fn;
        rq.addr      = ad;
        rq.size_code = sz;
        rq.wdata     = wd;
        rq.drain     = drain;
        rq.calm      = calm;
        req_backlog.push_back(rq);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request driver: predict on accept, then load the next item or idle.
    // Counters move by nonblocking assignment so the drain test reads the
    // values from before the edge, whatever order the processes run in.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        bit took;
        bit drained;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            took = req_if.valid && req_if.ready;
            if (took) begin
                predicted_rsp_q.push_back(mem_model_access(cur_req));
                reqs_taken <= reqs_taken + 1;
            end
            if (!req_if.valid || took) begin
                drained = (reqs_taken + int'(took)) == rsps_taken;
                if (req_backlog.size() != 0 && (!req_backlog[0].drain || drained) &&
                    (req_backlog[0].calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_req = req_backlog.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.func         <= cur_req.func;
                    req_if.byte_address <= cur_req.addr;
                    req_if.size_code    <= cur_req.size_code;
                    req_if.write_data   <= cur_req.wdata;
                    calm_mode           <= cur_req.calm;
                end else begin
                    // Idle, or hold a drain item until the block is empty
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // prediction; stall ready at random outside the calm stretch.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_mem_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsps_taken <= rsps_taken + 1;
                if (predicted_rsp_q.size() == 0) begin
                    n_errors = n_errors + 1;
                    $display("%0t: result with none owed: read_data=%h status=%0d",
                             $time, rsp_if.read_data, rsp_if.status);
                end else begin
                    want = predicted_rsp_q.pop_front();
                    if (rsp_if.read_data !== want.rdata) begin
                        n_errors = n_errors + 1;
                        $display("%0t: read_data mismatch: expected %h actual %h",
                                 $time, want.rdata, rsp_if.read_data);
                    end
                    if (rsp_if.status !== want.status) begin
                        n_errors = n_errors + 1;
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                    end
                end
            end
            rsp_if.ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when neither side has moved for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stim
        logic [TAG_W-1:0] page_pool [POOL];
        logic [TAG_W-1:0] tg;
        logic [63:0]      rnd;
        logic [63:0]      ad;
        logic [63:0]      wd;
        logic [11:0]      off;
        logic [1:0]       fn;
        logic [1:0]       sz;
        int               r;

        // Hold every input at a known value from time zero
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.func         = FN_READ;
        req_if.byte_address = '0;
        req_if.size_code    = SZ_1B;
        req_if.write_data   = '0;
        rsp_if.ready        = 1'b0;
        reqs_taken          = 0;
        rsps_taken          = 0;
        n_errors            = 0;
        calm_mode           = 1'b0;
        for (int i = 0; i < TB_PAGES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            for (int b = 0; b < PAGE_BYTES; b++)
                shadow_bytes[i][b] = 8'h00;
        end

        // Directed: empty table answers
        queue_req(FN_READ, 64'h0, SZ_1B, 64'h0, 1'b0, 1'b0);
        queue_req(FN_FREE, '1, SZ_8B, '1, 1'b0, 1'b0);
        queue_req(FN_UNUSED, 64'h5A5A_0000_1234_5678, SZ_4B, '1, 1'b0, 1'b0);
        // Crossing write at the top of the address space must not allocate,
        // so the unmapped-and-crossing read that follows still sees no page
        queue_req(FN_WRITE, '1, SZ_8B, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        queue_req(FN_READ, '1, SZ_8B, 64'h0, 1'b0, 1'b0);
        // Allocate page 0 and read the word back at each width and sign
        queue_req(FN_WRITE, 64'h0, SZ_8B, 64'h8000_0000_0000_0001, 1'b0, 1'b0);
        queue_req(FN_READ, 64'h0, SZ_1B, 64'h0, 1'b0, 1'b0);
        queue_req(FN_READ, 64'h6, SZ_2B, 64'h0, 1'b0, 1'b0);
        queue_req(FN_READ, 64'h4, SZ_4B, 64'h0, 1'b0, 1'b0);
        queue_req(FN_READ, 64'h0, SZ_8B, 64'h0, 1'b0, 1'b0);
        // Crossings within a mapped page
        queue_req(FN_READ, 64'hFFF, SZ_2B, 64'h0, 1'b0, 1'b0);
        queue_req(FN_WRITE, 64'hFFC, SZ_8B, '1, 1'b0, 1'b0);
        // Fill the rest of the table; the last page sits at the top of memory
        for (int p = 1; p < TB_PAGES - 1; p++)
            queue_req(FN_WRITE, {TAG_W'(p), 12'(p * 8)}, SZ_8B,
                      (p % 2) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFEDC_BA98_7654_3210,
                      1'b0, 1'b0);
        queue_req(FN_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, SZ_8B, '1, 1'b0, 1'b0);
        // Table full, then last byte of memory
        queue_req(FN_WRITE, 64'h0000_0000_1234_5000, SZ_1B, 64'h55, 1'b0, 1'b0);
        queue_req(FN_READ, '1, SZ_1B, 64'h0, 1'b0, 1'b0);
        // Free page 3; a new page takes its slot and must read back cleared
        queue_req(FN_FREE, 64'h0000_0000_0000_37A5, SZ_2B, '1, 1'b0, 1'b0);
        queue_req(FN_WRITE, 64'h0000_0000_ABCD_E010, SZ_2B, 64'h7FFF_FFFF_FFFF_8001,
                  1'b0, 1'b0);
        queue_req(FN_READ, 64'h0000_0000_ABCD_E018, SZ_8B, 64'h0, 1'b0, 1'b0);

        // Pool: every page mapped by the directed items plus random ones, so the table keeps
        // filling up and draining
        for (int i = 0; i < TB_PAGES - 1; i++)
            page_pool[i] = TAG_W'(i);
        page_pool[TB_PAGES - 1] = '1;
        page_pool[TB_PAGES]     = TAG_W'(64'hABCDE);
        for (int i = TB_PAGES + 1; i < POOL; i++) begin
            rnd = {$urandom, $urandom};
            page_pool[i] = rnd[TAG_W-1:0];
        end

        // Random: mostly writes and reads on pool pages, with frees,
        // noise addresses and the unused code mixed in
        for (int n = 0; n < RAND_ITEMS; n++) begin
            r  = $urandom_range(99);
            tg = page_pool[$urandom_range(POOL - 1)];
            if (r < 50)
                off = 12'($urandom_range(63));
            else if (r < 65)
                off = 12'(PAGE_BYTES - $urandom_range(16, 1));
            else
                off = 12'($urandom);
            ad = {tg, off};
            sz = 2'($urandom_range(3));
            wd = {$urandom, $urandom};
            r  = $urandom_range(99);
            if (r < 3) begin
                fn = FN_UNUSED;
                ad = {$urandom, $urandom};
            end else if (r < 9) begin
                fn = FN_FREE;
            end else if (r < 14) begin
                fn = ($urandom_range(1) == 0) ? FN_READ : FN_FREE;
                ad = {$urandom, $urandom};
            end else if (r < 55) begin
                fn = FN_WRITE;
            end else begin
                fn = FN_READ;
            end
            queue_req(fn, ad, sz, wd, (n == 0) || (n == RAND_ITEMS / 2),
                      (n >= CALM_LO) && (n < CALM_HI));
        end

        // Release reset at a rising edge
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Poll away from the active edge: wait until everything is owed back
        do
            @(negedge i_clk);
        while (req_backlog.size() != 0 || req_if.valid || reqs_taken != rsps_taken);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (n_errors == 0 && predicted_rsp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
